>>> hdl/esv_pkg.sv
// shared types and constants of the elgamal sign and verify engine
package esv_pkg;

  localparam int FIELD_W   = 31;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 1;
  // signed width of the extended euclid coefficients and their partial products
  localparam int TW        = 34;

  localparam logic [REQ_W-1:0] REQ_KEYGEN = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SIGN   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_VERIFY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GENERATOR = 1'b1;

  localparam logic [FIELD_W-1:0] MODULUS_RESET   = 31'd23;
  localparam logic [FIELD_W-1:0] GENERATOR_RESET = 31'd5;

  typedef struct packed {
    logic                 done;
    logic signed [TW-1:0] coef;
  } eu_rsp_t;

endpackage

>>> hdl/esv_intf.sv
// request, response and configuration channel interfaces
interface esv_req_if import esv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [FIELD_W-1:0] secret_key;
  logic [FIELD_W-1:0] session_key;
  logic [FIELD_W-1:0] message;
  logic [FIELD_W-1:0] sig_first;
  logic [FIELD_W-1:0] sig_second;
  logic [FIELD_W-1:0] public_key;
  modport source (output valid, req_type, secret_key, session_key, message, sig_first,
                  sig_second, public_key, input ready);
  modport sink (input valid, req_type, secret_key, session_key, message, sig_first,
                sig_second, public_key, output ready);
endinterface

interface esv_rsp_if import esv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] value_first;
  logic [FIELD_W-1:0] value_second;
  logic               sig_valid;
  modport source (output valid, value_first, value_second, sig_valid, input ready);
  modport sink (input valid, value_first, value_second, sig_valid, output ready);
endinterface

interface esv_cfg_if import esv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIELD_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/esv_modmul.sv
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
module esv_modmul #(
  parameter int MW = 31,
  parameter int XW = 34
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [XW-1:0] x_i,
  input  logic [MW-1:0] y_i,
  input  logic [MW-1:0] m_i,
  output logic          done_o,
  output logic [MW-1:0] res_o
);

  localparam int CW = $clog2(XW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [XW-1:0] x_q;
  logic [MW-1:0] y_q;
  logic [MW-1:0] m_q;
  logic [MW-1:0] acc_q;
  logic [MW-1:0] acc_d;
  logic [MW+1:0] sum;
  logic [MW+1:0] m1;
  logic [MW+1:0] m2;

  // acc < m and y < m, so the sum stays below 3m
  always_comb begin
    sum = {1'b0, acc_q, 1'b0} + (x_q[XW-1] ? {2'b00, y_q} : '0);
    m1  = {2'b00, m_q};
    m2  = {1'b0, m_q, 1'b0};
    if (sum >= m2) begin
      acc_d = MW'(sum - m2);
    end else if (sum >= m1) begin
      acc_d = MW'(sum - m1);
    end else begin
      acc_d = MW'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(XW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      y_q   <= y_i;
      m_q   <= m_i;
      acc_q <= '0;
    end else if (busy_q) begin
      x_q   <= {x_q[XW-2:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

>>> hdl/esv_euclid.sv
// extended euclid with a restoring divider, gives the bezout coefficient of k
module esv_euclid import esv_pkg::*; #(
  parameter int MW = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [FIELD_W-1:0] k_i,
  input  logic [MW-1:0]      n_i,
  output eu_rsp_t            rsp_o
);

  localparam int DW = FIELD_W;
  localparam int CW = $clog2(DW + 1);

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_CHK  = 2'd1;
  localparam logic [1:0] E_DIV  = 2'd2;

  localparam logic signed [TW-1:0] SZERO = '0;
  localparam logic signed [TW-1:0] SONE  = TW'(1);

  logic [1:0]           st_q;
  logic                 done_q;
  logic [CW-1:0]        cnt_q;
  logic [DW-1:0]        or_q;
  logic [DW-1:0]        r_q;
  logic [DW-1:0]        dvd_q;
  logic [DW-1:0]        rem_q;
  logic signed [TW-1:0] ot_q;
  logic signed [TW-1:0] t_q;
  logic signed [TW-1:0] qt_q;

  logic [DW:0]          trial;
  logic                 ge;
  logic [DW-1:0]        rem_n;
  logic signed [TW-1:0] qt_n;

  // one quotient bit per cycle; q*t is built alongside by shift and add
  always_comb begin
    trial = {rem_q, dvd_q[DW-1]};
    ge    = trial >= {1'b0, r_q};
    rem_n = ge ? DW'(trial - {1'b0, r_q}) : DW'(trial);
    qt_n  = (qt_q <<< 1) + (ge ? t_q : SZERO);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= E_IDLE;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        E_IDLE: begin
          if (start_i) begin
            st_q <= E_CHK;
          end
        end
        E_CHK: begin
          if (r_q == '0) begin
            done_q <= 1'b1;
            st_q   <= E_IDLE;
          end else begin
            cnt_q <= CW'(DW);
            st_q  <= E_DIV;
          end
        end
        E_DIV: begin
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            st_q <= E_CHK;
          end
        end
        default: begin
          st_q <= E_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == E_IDLE && start_i) begin
      or_q <= DW'(n_i);
      r_q  <= k_i;
      ot_q <= SZERO;
      t_q  <= SONE;
    end else if (st_q == E_CHK) begin
      rem_q <= '0;
      dvd_q <= or_q;
      qt_q  <= SZERO;
    end else if (st_q == E_DIV) begin
      rem_q <= rem_n;
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      qt_q  <= qt_n;
      if (cnt_q == CW'(1)) begin
        or_q <= r_q;
        r_q  <= rem_n;
        ot_q <= t_q;
        t_q  <= ot_q - qt_n;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.coef = ot_q;

endmodule

>>> hdl/elgamal_sign_verify_engine_core.sv
// a power reduces the base, then until the exponent is zero takes a test step, a multiply when
// its low bit is set and a square; key generation is one power, signing one power, extended
// euclid and five multiplies modulo p-1, verification three powers and one multiply; every
// multiply goes through the bit-serial multiplier
// one request at a time, the input is ready only while the sequencer is idle
// reset clears control state and sets modulus to 23 and generator to 5
module elgamal_sign_verify_engine_core import esv_pkg::*; #(
  parameter int MOD_BITS = 31
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  esv_req_if.sink  req_i,
  esv_rsp_if.source rsp_o,
  esv_cfg_if.sink  cfg_i
);

  localparam int MW = MOD_BITS;
  localparam int XW = TW;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_POW_RED  = 4'd1;
  localparam logic [3:0] S_POW_TEST = 4'd2;
  localparam logic [3:0] S_POW_MUL  = 4'd3;
  localparam logic [3:0] S_POW_SQR  = 4'd4;
  localparam logic [3:0] S_DISPATCH = 4'd5;
  localparam logic [3:0] S_SG_EU    = 4'd6;
  localparam logic [3:0] S_SG_RCO   = 4'd7;
  localparam logic [3:0] S_SG_RMSG  = 4'd8;
  localparam logic [3:0] S_SG_RA    = 4'd9;
  localparam logic [3:0] S_SG_XA    = 4'd10;
  localparam logic [3:0] S_SG_B     = 4'd11;
  localparam logic [3:0] S_VF_LHS   = 4'd12;
  localparam logic [3:0] S_OUT      = 4'd13;

  logic [3:0]         state_q;
  logic [1:0]         phase_q;
  logic               mm_busy_q;
  logic               eu_busy_q;
  logic [MW-1:0]      p_q;
  logic [MW-1:0]      g_q;
  logic [REQ_W-1:0]   req_q;
  logic [FIELD_W-1:0] xs_q;
  logic [FIELD_W-1:0] ks_q;
  logic [FIELD_W-1:0] msg_q;
  logic [FIELD_W-1:0] sa_q;
  logic [FIELD_W-1:0] sb_q;
  logic [FIELD_W-1:0] base_q;
  logic [FIELD_W-1:0] exp_q;
  logic [MW-1:0]      acc_q;
  logic [MW-1:0]      sq_q;
  logic [MW-1:0]      t0_q;
  logic [MW-1:0]      t1_q;
  logic [MW-1:0]      r0_q;
  logic [MW-1:0]      r1_q;
  logic               rv_q;
  logic               co_neg_q;
  logic [XW-1:0]      co_mag_q;
  logic               out_valid_q;
  logic [MW-1:0]      out_first_q;
  logic [MW-1:0]      out_second_q;
  logic               out_sig_q;

  logic               mm_state;
  logic               mm_start;
  logic               mm_done;
  logic [XW-1:0]      mm_x;
  logic [MW-1:0]      mm_y;
  logic [MW-1:0]      mm_m;
  logic [MW-1:0]      mm_res;
  logic [MW-1:0]      n_w;
  logic               eu_start;
  eu_rsp_t            eu_rsp;
  logic               in_fire;
  logic               out_load;

  assign n_w      = p_q - MW'(1);
  assign in_fire  = req_i.valid && (state_q == S_IDLE);
  assign out_load = (state_q == S_OUT) && (!out_valid_q || rsp_o.ready);
  assign mm_start = mm_state && !mm_busy_q;
  assign eu_start = (state_q == S_SG_EU) && !eu_busy_q;

  // operands of the shared multiplier for each step
  always_comb begin
    mm_state = 1'b1;
    mm_x     = '0;
    mm_y     = MW'(1);
    mm_m     = p_q;
    unique case (state_q)
      S_POW_RED: begin
        mm_x = XW'(base_q);
      end
      S_POW_MUL: begin
        mm_x = XW'(sq_q);
        mm_y = acc_q;
      end
      S_POW_SQR: begin
        mm_x = XW'(sq_q);
        mm_y = sq_q;
      end
      S_SG_RCO: begin
        mm_x = co_mag_q;
        mm_m = n_w;
      end
      S_SG_RMSG: begin
        mm_x = XW'(msg_q);
        mm_m = n_w;
      end
      S_SG_RA: begin
        mm_x = XW'(r0_q);
        mm_m = n_w;
      end
      S_SG_XA: begin
        mm_x = XW'(xs_q);
        mm_y = acc_q;
        mm_m = n_w;
      end
      S_SG_B: begin
        mm_x = XW'(acc_q);
        mm_y = t1_q;
        mm_m = n_w;
      end
      S_VF_LHS: begin
        mm_x = XW'(t0_q);
        mm_y = t1_q;
      end
      default: begin
        mm_state = 1'b0;
      end
    endcase
  end

  esv_modmul #(
    .MW (MW),
    .XW (XW)
  ) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .x_i     (mm_x),
    .y_i     (mm_y),
    .m_i     (mm_m),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  esv_euclid #(
    .MW (MW)
  ) u_euclid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (eu_start),
    .k_i     (ks_q),
    .n_i     (n_w),
    .rsp_o   (eu_rsp)
  );

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= MODULUS_RESET[MW-1:0];
      g_q <= GENERATOR_RESET[MW-1:0];
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_MODULUS:   p_q <= cfg_i.data[MW-1:0];
        REG_GENERATOR: g_q <= cfg_i.data[MW-1:0];
        default:       p_q <= p_q;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      mm_busy_q   <= 1'b0;
      eu_busy_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mm_start) begin
        mm_busy_q <= 1'b1;
      end else if (mm_done) begin
        mm_busy_q <= 1'b0;
      end
      if (eu_start) begin
        eu_busy_q <= 1'b1;
      end else if (eu_rsp.done) begin
        eu_busy_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            phase_q <= '0;
            if (p_q < MW'(3)) begin
              state_q <= S_OUT;
            end else if (req_i.req_type == REQ_KEYGEN || req_i.req_type == REQ_SIGN ||
                         req_i.req_type == REQ_VERIFY) begin
              state_q <= S_POW_RED;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_POW_RED: begin
          if (mm_done) state_q <= S_POW_TEST;
        end
        S_POW_TEST: begin
          if (exp_q == '0) begin
            state_q <= S_DISPATCH;
          end else if (exp_q[0]) begin
            state_q <= S_POW_MUL;
          end else begin
            state_q <= S_POW_SQR;
          end
        end
        S_POW_MUL: begin
          if (mm_done) state_q <= S_POW_SQR;
        end
        S_POW_SQR: begin
          if (mm_done) state_q <= S_POW_TEST;
        end
        S_DISPATCH: begin
          unique case (req_q)
            REQ_SIGN: state_q <= S_SG_EU;
            REQ_VERIFY: begin
              unique case (phase_q)
                2'd0: begin
                  phase_q <= 2'd1;
                  state_q <= S_POW_RED;
                end
                2'd1: state_q <= S_VF_LHS;
                default: state_q <= S_OUT;
              endcase
            end
            default: state_q <= S_OUT;
          endcase
        end
        S_SG_EU: begin
          if (eu_rsp.done) state_q <= S_SG_RCO;
        end
        S_SG_RCO: begin
          if (mm_done) state_q <= S_SG_RMSG;
        end
        S_SG_RMSG: begin
          if (mm_done) state_q <= S_SG_RA;
        end
        S_SG_RA: begin
          if (mm_done) state_q <= S_SG_XA;
        end
        S_SG_XA: begin
          if (mm_done) state_q <= S_SG_B;
        end
        S_SG_B: begin
          if (mm_done) state_q <= S_OUT;
        end
        S_VF_LHS: begin
          if (mm_done) begin
            phase_q <= 2'd2;
            state_q <= S_POW_RED;
          end
        end
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          req_q <= req_i.req_type;
          xs_q  <= req_i.secret_key;
          ks_q  <= req_i.session_key;
          msg_q <= req_i.message;
          sa_q  <= req_i.sig_first;
          sb_q  <= req_i.sig_second;
          acc_q <= MW'(1);
          r0_q  <= '0;
          r1_q  <= '0;
          rv_q  <= 1'b0;
          unique case (req_i.req_type)
            REQ_KEYGEN: begin
              base_q <= FIELD_W'(g_q);
              exp_q  <= req_i.secret_key;
            end
            REQ_SIGN: begin
              base_q <= FIELD_W'(g_q);
              exp_q  <= req_i.session_key;
            end
            default: begin
              base_q <= req_i.public_key;
              exp_q  <= req_i.sig_first;
            end
          endcase
        end
      end
      S_POW_RED: begin
        if (mm_done) sq_q <= mm_res;
      end
      S_POW_MUL: begin
        if (mm_done) acc_q <= mm_res;
      end
      S_POW_SQR: begin
        if (mm_done) begin
          sq_q  <= mm_res;
          exp_q <= exp_q >> 1;
        end
      end
      S_DISPATCH: begin
        if (req_q == REQ_VERIFY) begin
          unique case (phase_q)
            2'd0: begin
              t0_q   <= acc_q;
              base_q <= sa_q;
              exp_q  <= sb_q;
              acc_q  <= MW'(1);
            end
            2'd1: t1_q <= acc_q;
            default: rv_q <= (t0_q == acc_q);
          endcase
        end else begin
          r0_q <= acc_q;
        end
      end
      S_SG_EU: begin
        if (eu_rsp.done) begin
          co_neg_q <= eu_rsp.coef[TW-1];
          co_mag_q <= eu_rsp.coef[TW-1] ? $unsigned(-eu_rsp.coef) : $unsigned(eu_rsp.coef);
        end
      end
      S_SG_RCO: begin
        // bezout coefficient taken into 0 .. n-1
        if (mm_done) t1_q <= (co_neg_q && mm_res != '0) ? n_w - mm_res : mm_res;
      end
      S_SG_RMSG: begin
        if (mm_done) t0_q <= mm_res;
      end
      S_SG_RA: begin
        if (mm_done) acc_q <= mm_res;
      end
      S_SG_XA: begin
        if (mm_done) acc_q <= (t0_q >= mm_res) ? t0_q - mm_res : t0_q + (n_w - mm_res);
      end
      S_SG_B: begin
        if (mm_done) r1_q <= mm_res;
      end
      S_VF_LHS: begin
        if (mm_done) begin
          t0_q   <= mm_res;
          base_q <= FIELD_W'(g_q);
          exp_q  <= msg_q;
          acc_q  <= MW'(1);
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_first_q  <= r0_q;
          out_second_q <= r1_q;
          out_sig_q    <= rv_q;
        end
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.value_first  = FIELD_W'(out_first_q);
  assign rsp_o.value_second = FIELD_W'(out_second_q);
  assign rsp_o.sig_valid    = out_sig_q;

`ifndef NO_ASSERTIONS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q != S_IDLE))
    else $error("accepted beat did not start the sequencer");

  a_verify_zero_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.sig_valid) |-> (rsp_o.value_first == '0 && rsp_o.value_second == '0))
    else $error("verify result carries nonzero values");

  a_first_below_modulus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && p_q >= MW'(3)) |-> (rsp_o.value_first < FIELD_W'(p_q)))
    else $error("first result value not reduced by the modulus");
`endif

endmodule
